// ===== rtl/ptts_pkg.sv =====
// Package for the periodic task tick scheduler.
// Holds the configuration register indexes, reset constants and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 4;
  localparam int TASK_W    = 3;
  localparam int JOB_W     = 16;
  localparam int IDLE_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_TASK_COUNT = 2'd1,
    CFG_COMPUTE    = 2'd2,
    CFG_PERIODS    = 2'd3
  } cfg_index_t;

  localparam logic MODE_EDF = 1'b0;
  localparam logic MODE_RM  = 1'b1;

  localparam logic [CFG_W-1:0]   PACKED_RESET     = 64'h0101_0101_0101_0101;
  localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/ptts_req_if.sv =====
// Request channel of the scheduler: one transaction per time slot.
// Depends on nothing but the valid/ready convention.
`timescale 1ns / 1ps
`default_nettype none

interface ptts_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptts_rsp_if.sv =====
// Response channel of the scheduler: one transaction per scheduled slot.
// Depends on ptts_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ptts_rsp_if import ptts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              slot_idle;
  logic [TASK_W-1:0] task_index;
  logic [JOB_W-1:0]  job_number;
  logic              job_finished;
  logic [IDLE_W-1:0] idle_run_before;

  modport source (output valid, output slot_idle, output task_index, output job_number,
                  output job_finished, output idle_run_before, input ready);
  modport sink   (input valid, input slot_idle, input task_index, input job_number,
                  input job_finished, input idle_run_before, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptts_task_regs.sv =====
// Per-task state store: compute left, deadline left, ready flag and job count.
// One read and one write per cycle at the same sweep index. Depends on ptts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptts_task_regs import ptts_pkg::*; #(
  parameter int TASKS      = 8,
  parameter int VALUE_BITS = 8,
  parameter int IDX_W      = 3
) (
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire logic                  we,
  input  wire logic [VALUE_BITS-1:0] wr_compute,
  input  wire logic [VALUE_BITS-1:0] wr_deadline,
  input  wire logic                  wr_ready,
  input  wire logic [JOB_W-1:0]      wr_job,
  output logic      [VALUE_BITS-1:0] rd_compute,
  output logic      [VALUE_BITS-1:0] rd_deadline,
  output logic                       rd_ready,
  output logic      [JOB_W-1:0]      rd_job
);

  logic [VALUE_BITS-1:0] compute_left  [TASKS];
  logic [VALUE_BITS-1:0] deadline_left [TASKS];
  logic                  ready_flag    [TASKS];
  logic [JOB_W-1:0]      job_count     [TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      compute_left[idx]  <= wr_compute;
      deadline_left[idx] <= wr_deadline;
      ready_flag[idx]    <= wr_ready;
      job_count[idx]     <= wr_job;
    end
  end

  assign rd_compute  = compute_left[idx];
  assign rd_deadline = deadline_left[idx];
  assign rd_ready    = ready_flag[idx];
  assign rd_job      = job_count[idx];

endmodule

`default_nettype wire

// ===== rtl/periodic_task_tick_scheduler_core.sv =====
// Periodic task tick scheduler: EDF or non-preemptive rate monotonic, one slot per request.
// Each accepted request walks the single task-state sweep port over the n tasks in use,
// once to scan and once to update, then loads the result into the output register, waiting
// there while that register still holds an unaccepted response; a restart first adds a
// reload pass over all TASKS entries. A new request is taken only once the sequencer is idle.
// Reset: synchronous, active high; afterwards a reload pass loads every task slot from the
// reset register values, during which no request is taken.
// Depends on ptts_pkg, ptts_req_if, ptts_rsp_if and ptts_task_regs.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_tick_scheduler_core import ptts_pkg::*; #(
  parameter int TASKS      = 8,
  parameter int VALUE_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  ptts_req_if.sink                  req,
  ptts_rsp_if.source                rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Sweep counter holds the task count itself; the index is its low part.
  localparam int CNT_W = $clog2(TASKS + 1);
  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [VALUE_BITS-1:0] VAL_ONE = VALUE_BITS'(1);

  // Configuration registers.
  logic               mode;
  logic [COUNT_W-1:0] task_count;
  logic [CFG_W-1:0]   compute_times;
  logic [CFG_W-1:0]   periods;

  // Sequencer and working registers.
  seq_state_t            state, state_next;
  logic [CNT_W-1:0]      cnt;
  logic                  init_pass;
  logic                  found;
  logic                  keep;
  logic [VALUE_BITS-1:0] best;
  logic [IDX_W-1:0]      sel;
  logic [IDX_W-1:0]      cur;
  logic                  cur_valid;
  logic [IDLE_W-1:0]     idle_run;
  logic [JOB_W-1:0]      res_job;
  logic                  res_fin;

  // Output register.
  logic              out_valid;
  logic              out_idle;
  logic [TASK_W-1:0] out_task;
  logic [JOB_W-1:0]  out_job;
  logic              out_fin;
  logic [IDLE_W-1:0] out_idle_before;

  logic [IDX_W-1:0] idx;
  assign idx = cnt[IDX_W-1:0];

  // Tasks in use: zero counts as one, anything above TASKS as TASKS.
  logic [CNT_W-1:0] n_use;
  always_comb begin
    if (task_count == '0) begin
      n_use = CNT_W'(1);
    end else if ({1'b0, task_count} > (COUNT_W+1)'(TASKS)) begin
      n_use = CNT_W'(TASKS);
    end else begin
      n_use = CNT_W'(task_count);
    end
  end

  logic last_use;
  logic last_all;
  assign last_use = (CNT_W'(cnt + 1'b1) == n_use);
  assign last_all = (CNT_W'(cnt + 1'b1) == CNT_W'(TASKS));

  // Packed per-task values. The reload pass after reset takes the reset words so that
  // a register write landing during that pass cannot leak into the initial state.
  logic [CFG_W-1:0]      ct_src;
  logic [CFG_W-1:0]      pd_src;
  logic [VALUE_BITS-1:0] ct_slice [TASKS];
  logic [VALUE_BITS-1:0] pd_slice [TASKS];

  assign ct_src = init_pass ? PACKED_RESET : compute_times;
  assign pd_src = init_pass ? PACKED_RESET : periods;

  for (genvar k = 0; k < TASKS; k++) begin : g_slice
    localparam int LO = k * VALUE_BITS;
    if (LO + VALUE_BITS <= CFG_W) begin : g_full
      assign ct_slice[k] = ct_src[LO +: VALUE_BITS];
      assign pd_slice[k] = pd_src[LO +: VALUE_BITS];
    end else if (LO < CFG_W) begin : g_part
      // Slice runs off the top of the word; the missing bits read as zero.
      assign ct_slice[k] = VALUE_BITS'(ct_src[CFG_W-1:LO]);
      assign pd_slice[k] = VALUE_BITS'(pd_src[CFG_W-1:LO]);
    end else begin : g_none
      assign ct_slice[k] = '0;
      assign pd_slice[k] = '0;
    end
  end

  // A packed value of zero is used as one.
  logic [VALUE_BITS-1:0] pv_ct;
  logic [VALUE_BITS-1:0] pv_pd;
  assign pv_ct = (ct_slice[idx] == '0) ? VAL_ONE : ct_slice[idx];
  assign pv_pd = (pd_slice[idx] == '0) ? VAL_ONE : pd_slice[idx];

  // Task state store, swept one entry per cycle.
  logic                  st_we;
  logic [VALUE_BITS-1:0] wr_compute;
  logic [VALUE_BITS-1:0] wr_deadline;
  logic                  wr_ready;
  logic [JOB_W-1:0]      wr_job;
  logic [VALUE_BITS-1:0] rd_compute;
  logic [VALUE_BITS-1:0] rd_deadline;
  logic                  rd_ready;
  logic [JOB_W-1:0]      rd_job;

  ptts_task_regs #(
    .TASKS      (TASKS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_task_regs (
    .clk         (clk),
    .idx         (idx),
    .we          (st_we),
    .wr_compute  (wr_compute),
    .wr_deadline (wr_deadline),
    .wr_ready    (wr_ready),
    .wr_job      (wr_job),
    .rd_compute  (rd_compute),
    .rd_deadline (rd_deadline),
    .rd_ready    (rd_ready),
    .rd_job      (rd_job)
  );

  // Scan step: the compare unit checks the swept task against the best so far.
  // Earliest deadline first ranks by deadline left, rate monotonic by the live period.
  logic [VALUE_BITS-1:0] metric;
  logic                  better;
  logic                  keep_hit;
  assign metric   = (mode == MODE_RM) ? pv_pd : rd_deadline;
  assign better   = rd_ready && (!found || (metric < best));
  // In rate monotonic mode the task that ran last keeps the processor while ready.
  assign keep_hit = (mode == MODE_RM) && cur_valid && (cur == idx) && rd_ready;

  logic [IDX_W-1:0] sel_eff;
  logic             found_eff;
  assign sel_eff   = keep ? cur : sel;
  assign found_eff = keep || found;

  // Update step: charge the chosen task one unit, then count down the period of every task in use.
  logic                  hit;
  logic [VALUE_BITS-1:0] c_dec;
  logic [VALUE_BITS-1:0] c_after;
  logic                  fin;
  logic                  rdy_after;
  logic [JOB_W-1:0]      job_after;
  logic                  dl_expired;
  assign hit        = found_eff && (idx == sel_eff);
  assign c_dec      = (rd_compute != '0) ? VALUE_BITS'(rd_compute - 1'b1) : rd_compute;
  assign c_after    = hit ? c_dec : rd_compute;
  assign fin        = hit && (c_dec == '0);
  assign rdy_after  = fin ? 1'b0 : rd_ready;
  assign job_after  = fin ? JOB_W'(rd_job + 1'b1) : rd_job;
  assign dl_expired = (rd_deadline <= VAL_ONE);

  logic out_load;
  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = req.restart ? ST_RELOAD : ST_SCAN;
        end
      end
      ST_RELOAD: begin
        if (last_all) begin
          state_next = init_pass ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_use) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (last_use) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Store write data per state.
  always_comb begin
    st_we       = 1'b0;
    wr_compute  = pv_ct;
    wr_deadline = pv_pd;
    wr_ready    = 1'b1;
    wr_job      = JOB_W'(1);
    unique case (state)
      ST_RELOAD: begin
        st_we = 1'b1;
      end
      ST_UPDATE: begin
        st_we       = 1'b1;
        wr_compute  = dl_expired ? pv_ct : c_after;
        wr_deadline = dl_expired ? pv_pd : VALUE_BITS'(rd_deadline - 1'b1);
        wr_ready    = dl_expired || rdy_after;
        wr_job      = job_after;
      end
      ST_IDLE, ST_SCAN, ST_DONE: begin
        st_we = 1'b0;
      end
      default: st_we = 1'b0;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_EDF;
      task_count    <= TASK_COUNT_RESET;
      compute_times <= PACKED_RESET;
      periods       <= PACKED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MODE:       mode          <= cfg_data[0];
        CFG_TASK_COUNT: task_count    <= cfg_data[COUNT_W-1:0];
        CFG_COMPUTE:    compute_times <= cfg_data;
        CFG_PERIODS:    periods       <= cfg_data;
        default:        mode          <= mode;
      endcase
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RELOAD;
      cnt       <= '0;
      init_pass <= 1'b1;
      found     <= 1'b0;
      keep      <= 1'b0;
      cur_valid <= 1'b0;
      idle_run  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cnt     <= '0;
            found   <= 1'b0;
            keep    <= 1'b0;
            res_fin <= 1'b0;
            res_job <= '0;
          end
        end
        ST_RELOAD: begin
          // Restart and reset forget the running task and the idle count.
          cur_valid <= 1'b0;
          idle_run  <= '0;
          cnt       <= last_all ? '0 : CNT_W'(cnt + 1'b1);
          if (last_all) begin
            init_pass <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (better) begin
            best  <= metric;
            sel   <= idx;
            found <= 1'b1;
          end
          if (keep_hit) begin
            keep <= 1'b1;
          end
          cnt <= last_use ? '0 : CNT_W'(cnt + 1'b1);
        end
        ST_UPDATE: begin
          if (hit) begin
            res_job <= rd_job;
            res_fin <= fin;
          end
          cnt <= last_use ? '0 : CNT_W'(cnt + 1'b1);
        end
        ST_DONE: begin
          if (out_load) begin
            if (found_eff) begin
              cur       <= sel_eff;
              cur_valid <= 1'b1;
              idle_run  <= '0;
            end else if (idle_run != '1) begin
              idle_run <= IDLE_W'(idle_run + 1'b1);
            end
          end
        end
        default: cnt <= '0;
      endcase
    end
  end

  // Task index reported on three bits, zero extended or masked as needed.
  logic [IDX_W+TASK_W-1:0] sel_wide;
  assign sel_wide = {{TASK_W{1'b0}}, sel_eff};

  // Output register: a finished result waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idle        <= !found_eff;
      out_task        <= found_eff ? sel_wide[TASK_W-1:0] : '0;
      out_job         <= found_eff ? res_job : '0;
      out_fin         <= found_eff && res_fin;
      out_idle_before <= found_eff ? idle_run : '0;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.slot_idle       = out_idle;
  assign rsp.task_index      = out_task;
  assign rsp.job_number      = out_job;
  assign rsp.job_finished    = out_fin;
  assign rsp.idle_run_before = out_idle_before;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for periodic_task_tick_scheduler_core.
// Drives time-slot transactions and register writes and checks every response against a
// typed or predicted expectation. Depends on ptts_pkg, ptts_req_if, ptts_rsp_if and the core.
`timescale 1ns / 1ps

module tb;
  import ptts_pkg::*;

  localparam int NUM_TASKS       = 8;
  localparam int VALUE_W         = 8;
  // Settling covers a slot's scan and update passes over all tasks plus a restart's reload
  // pass; allow some margin on top.
  localparam int SETTLE_CYCLES   = 2 * NUM_TASKS + 2 + NUM_TASKS + 6;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 200;
  localparam int MAX_PRINTS      = 20;

  typedef struct packed {
    logic              slot_idle;
    logic [TASK_W-1:0] task_index;
    logic [JOB_W-1:0]  job_number;
    logic              job_finished;
    logic [IDLE_W-1:0] idle_run_before;
  } slot_result_t;

  typedef enum logic {ROW_SLOT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    cfg_index_t   reg_idx;
    logic [CFG_W-1:0] data;
    logic         restart;
    logic         typed;
    slot_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_SHORT, RX_LONG} rx_style_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ptts_req_if req_ch ();
  ptts_rsp_if rsp_ch ();

  periodic_task_tick_scheduler_core #(
    .TASKS     (NUM_TASKS),
    .VALUE_BITS(VALUE_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Directed opening. Expected results are typed in only where they can be read off
  // directly; the other slot rows take their expectation from the predictor.
  stim_row_t directed_rows [36] = '{
    // Reset settings: one task, compute 1, period 1, so every slot finishes a job.
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b1, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b0, 3'd0, 16'd2, 1'b1, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b1, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b1, 16'd0}},
    // A task count of zero behaves as one task.
    '{ROW_WRITE, CFG_TASK_COUNT, 64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b1, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b1, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b0, 3'd0, 16'd2, 1'b1, 16'd0}},
    // Count above the slot total is clamped; zero compute and period values act as one.
    '{ROW_WRITE, CFG_TASK_COUNT, 64'd15, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_COMPUTE,    64'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_PERIODS,    64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b1, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b1, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b0, 3'd0, 16'd2, 1'b1, 16'd0}},
    // Largest compute and period everywhere: all tie, the lowest index keeps winning.
    '{ROW_WRITE, CFG_COMPUTE,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_PERIODS,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b1, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b0, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b0, 16'd0}},
    // One task with period 4: one run, three idle slots, then a run that reports them.
    '{ROW_WRITE, CFG_TASK_COUNT, 64'd1, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_COMPUTE,    64'd1, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_PERIODS,    64'd4, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b1, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b1, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b1, 3'd0, 16'd0, 1'b0, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b1, 3'd0, 16'd0, 1'b0, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b1, 3'd0, 16'd0, 1'b0, 16'd0}},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b1, '{1'b0, 3'd0, 16'd2, 1'b1, 16'd3}},
    // Rate monotonic over three tasks with distinct periods and compute times.
    '{ROW_WRITE, CFG_MODE,       64'd1, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_TASK_COUNT, 64'd3, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_COMPUTE,    64'h0000_0000_0002_0304, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_PERIODS,    64'h0000_0000_0005_0A14, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b1, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0},
    // Shrinking the count drops the remembered task out of use, so it is chosen afresh.
    '{ROW_WRITE, CFG_TASK_COUNT, 64'd1, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0},
    '{ROW_SLOT,  CFG_MODE,       64'd0, 1'b0, 1'b0, '0}
  };

  // Predictor copy of the registers and of the per-task scheduler state.
  logic               sched_mode;
  logic [COUNT_W-1:0] slot_count_cfg;
  logic [CFG_W-1:0]   compute_word;
  logic [CFG_W-1:0]   period_word;
  logic [VALUE_W-1:0] budget_left [NUM_TASKS];
  logic [VALUE_W-1:0] slack_left  [NUM_TASKS];
  logic               task_armed  [NUM_TASKS];
  logic [JOB_W-1:0]   job_seq     [NUM_TASKS];
  logic               holder_valid;
  int                 holder;
  logic [IDLE_W-1:0]  idle_slots;

  slot_result_t expected_slots [$];

  // Run statistics and stimulus controls shared between processes.
  int        mismatches    = 0;
  int        slots_sent    = 0;
  int        restarts_sent = 0;
  int        results_seen  = 0;
  int        idle_seen     = 0;
  int        finished_seen = 0;
  int        reg_writes    = 0;
  int        drain_pauses  = 0;
  int        burst_left    = 0;
  bit        tx_bursty     = 1'b0;
  rx_style_t rx_style      = RX_SHORT;
  int        hold_request  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard, sized well beyond the slowest legal run under the heaviest back-pressure.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // A packed field of zero is used as one.
  function automatic logic [VALUE_W-1:0] slot_value(logic [CFG_W-1:0] word, int i);
    logic [VALUE_W-1:0] v;
    v = word[i*VALUE_W +: VALUE_W];
    return (v == '0) ? VALUE_W'(1) : v;
  endfunction

  function automatic int active_tasks();
    int n;
    n = slot_count_cfg;
    if (n == 0) n = 1;
    if (n > NUM_TASKS) n = NUM_TASKS;
    return n;
  endfunction

  function automatic void reload_tasks();
    int i;
    for (i = 0; i < NUM_TASKS; i++) begin
      budget_left[i] = slot_value(compute_word, i);
      slack_left[i]  = slot_value(period_word, i);
      task_armed[i]  = 1'b1;
      job_seq[i]     = JOB_W'(1);
    end
    holder_valid = 1'b0;
    holder       = 0;
    idle_slots   = '0;
  endfunction

  // Advances the predictor by one time slot and returns the response it must produce.
  function automatic slot_result_t schedule_slot(logic restart);
    slot_result_t       r;
    int                 n;
    int                 j;
    int                 sel;
    bit                 found;
    logic [VALUE_W-1:0] best;
    logic [VALUE_W-1:0] m;
    if (restart) reload_tasks();
    n     = active_tasks();
    found = 1'b0;
    sel   = 0;
    best  = '1;
    r     = '0;
    if (sched_mode == MODE_RM && holder_valid && holder < n && task_armed[holder]) begin
      // Non-preemptive: the running task keeps the processor until its job ends.
      found = 1'b1;
      sel   = holder;
    end else begin
      for (j = 0; j < n; j++) begin
        if (task_armed[j]) begin
          m = (sched_mode == MODE_RM) ? slot_value(period_word, j) : slack_left[j];
          if (!found || m < best) begin
            best  = m;
            sel   = j;
            found = 1'b1;
          end
        end
      end
    end
    if (found) begin
      r.task_index      = TASK_W'(sel);
      r.job_number      = job_seq[sel];
      r.idle_run_before = idle_slots;
      idle_slots        = '0;
      if (budget_left[sel] != '0) budget_left[sel]--;
      if (budget_left[sel] == '0) begin
        task_armed[sel] = 1'b0;
        job_seq[sel]++;
        r.job_finished  = 1'b1;
      end
      holder_valid = 1'b1;
      holder       = sel;
    end else begin
      r.slot_idle = 1'b1;
      if (idle_slots != '1) idle_slots++;
    end
    // Period countdown after the choice; expiry reloads the task from the live registers.
    for (j = 0; j < n; j++) begin
      if (slack_left[j] <= VALUE_W'(1)) begin
        slack_left[j]  = slot_value(period_word, j);
        budget_left[j] = slot_value(compute_word, j);
        task_armed[j]  = 1'b1;
      end else begin
        slack_left[j]--;
      end
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_word();
    logic [CFG_W-1:0] w;
    int               i;
    for (i = 0; i < CFG_W / VALUE_W; i++) begin
      case ($urandom_range(0, 7))
        0:       w[i*VALUE_W +: VALUE_W] = '0;
        1:       w[i*VALUE_W +: VALUE_W] = VALUE_W'($urandom_range(0, 255));
        2:       w[i*VALUE_W +: VALUE_W] = VALUE_W'($urandom_range(7, 20));
        default: w[i*VALUE_W +: VALUE_W] = VALUE_W'($urandom_range(1, 6));
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input slot_result_t got,
                                 input slot_result_t want);
    string msg;
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      msg = $sformatf("%0d ns %s: got idle=%0b task=%0d job=%0d fin=%0b run=%0d",
                      $time, what, got.slot_idle, got.task_index, got.job_number,
                      got.job_finished, got.idle_run_before);
      msg = {msg, $sformatf(", want idle=%0b task=%0d job=%0d fin=%0b run=%0d",
                            want.slot_idle, want.task_index, want.job_number,
                            want.job_finished, want.idle_run_before)};
      $display("%s", msg);
    end
  endtask

  // Register write, applied to the predictor once the edge that takes it has passed.
  task automatic cfg_write(input cfg_index_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MODE:       sched_mode     = data[0];
      CFG_TASK_COUNT: slot_count_cfg = data[COUNT_W-1:0];
      CFG_COMPUTE:    compute_word   = data;
      CFG_PERIODS:    period_word    = data;
      default:        ;
    endcase
    reg_writes++;
  endtask

  // Offers one slot and returns at the edge where the transaction is accepted. Valid is
  // left high so a following slot can go out back to back.
  task automatic send_slot(input logic restart, input logic typed, input slot_result_t want);
    slot_result_t predicted;
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = schedule_slot(restart);
    expected_slots.push_back(typed ? want : predicted);
    slots_sent++;
    if (restart) restarts_sent++;
  endtask

  // Stops offering, lets every pending response come back and the core settle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Between random slots: now and then a full drain, otherwise burst and gap pacing.
  task automatic pace_sender();
    if ($urandom_range(0, 79) == 0) begin
      req_ch.valid <= 1'b0;
      while (expected_slots.size() != 0) @(posedge clk);
      @(posedge clk);
      drain_pauses++;
    end else if (tx_bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 20);
      end
    end
  endtask

  // Response side back-pressure. A long hold is counted here, independent of the sender,
  // so the core fills up and has to stall its request side.
  initial begin
    int run_left;
    int hold_left;
    bit level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
      end else if (rx_style == RX_ALWAYS) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level    = !level;
          run_left = (rx_style == RX_SHORT) ? $urandom_range(1, 3) : $urandom_range(1, 8);
        end
        run_left--;
        rsp_ch.ready <= level;
      end
    end
  end

  // Response checker: every accepted response is matched against the oldest expectation.
  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.slot_idle       = rsp_ch.slot_idle;
      got.task_index      = rsp_ch.task_index;
      got.job_number      = rsp_ch.job_number;
      got.job_finished    = rsp_ch.job_finished;
      got.idle_run_before = rsp_ch.idle_run_before;
      if (expected_slots.size() == 0) begin
        report_mismatch("unexpected response", got, '0);
      end else begin
        want = expected_slots.pop_front();
        if (got !== want) report_mismatch("response mismatch", got, want);
      end
      results_seen++;
      if (got.slot_idle) idle_seen++;
      if (got.job_finished) finished_seen++;
    end
  end

  // Main stimulus: directed table, then randomized register phases.
  initial begin
    int                 k;
    int                 phase;
    logic [COUNT_W-1:0] count_pick;

    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.restart <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_MODE;
    cfg_data       <= '0;

    sched_mode     = MODE_EDF;
    slot_count_cfg = TASK_COUNT_RESET;
    compute_word   = PACKED_RESET;
    period_word    = PACKED_RESET;
    reload_tasks();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The first slot waits on ready, which also covers the reload pass after reset.
    rx_style = RX_SHORT;
    for (k = 0; k < $size(directed_rows); k++) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(directed_rows[k].reg_idx, directed_rows[k].data);
      end else begin
        send_slot(directed_rows[k].restart, directed_rows[k].typed, directed_rows[k].want);
      end
    end

    // Random phases. Each starts from an idle core with fresh register values; a restart
    // on the first slot is optional so register changes also meet stale task state.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       count_pick = '0;
        1:       count_pick = COUNT_W'($urandom_range(9, 15));
        2:       count_pick = COUNT_W'(NUM_TASKS);
        default: count_pick = COUNT_W'($urandom_range(1, 4));
      endcase
      cfg_write(CFG_MODE, 64'($urandom_range(0, 1)));
      cfg_write(CFG_TASK_COUNT, 64'(count_pick));
      cfg_write(CFG_COMPUTE, pick_word());
      cfg_write(CFG_PERIODS, pick_word());
      rx_style   = rx_style_t'(phase % 3);
      tx_bursty  = (phase % 4) != 0;
      burst_left = $urandom_range(0, 20);
      if (phase == HOLD_PHASE) begin
        // Sender keeps offering while the response side is held off.
        tx_bursty    = 1'b0;
        hold_request = HOLD_CYCLES;
      end
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_slot((k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0),
                  1'b0, '0);
        pace_sender();
      end
    end

    wait_idle();

    $display("Ran %0d time slots (%0d restarts) across %0d register writes and %0d drains.",
             slots_sent, restarts_sent, reg_writes, drain_pauses);
    $display("Checked %0d responses: %0d idle slots, %0d finished jobs, %0d mismatches.",
             results_seen, idle_seen, finished_seen, mismatches);
    if (mismatches == 0 && expected_slots.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptts_pkg.sv
rtl/ptts_req_if.sv
rtl/ptts_rsp_if.sv
rtl/ptts_task_regs.sv
rtl/periodic_task_tick_scheduler_core.sv
tb/tb.sv
